FILE: sv/wspd_pkg.sv
// Shared types and constants for the WAV stream to PWM duty core.
// No dependencies; used by the core and by its port checker.
package wspd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] EvSample = 2'd0;
  localparam logic [1:0] EvHeader = 2'd1;
  localparam logic [1:0] EvError  = 2'd2;
  localparam logic [1:0] EvEnd    = 2'd3;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [7:0] CenterDuty = 8'd128;
  localparam logic [5:0] HeaderLast = 6'd35;
  localparam logic [15:0] DepthSixteen = 16'd16;
  localparam logic [15:0] ChanStereo   = 16'd2;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  pwm_duty;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] payload_bytes;
    logic        last_of_run;
  } result_t;

endpackage

FILE: sv/wav_stream_to_pwm_duty_core.sv
// WAV byte stream parser and sample to PWM duty converter.
// Depends on wspd_pkg for the result type, event codes and tags.

// Takes one file byte per cycle and parses the RIFF/WAVE header, finds the
// data chunk, then turns each sample frame into an 8-bit duty. All parsing
// and conversion sit in one combinational step between the state registers
// and a four-entry result queue, so an item is taken every cycle; an item
// yields at most two results, and in_ready_o drops only while fewer than two
// queue slots are free. Results leave at one per cycle while out_ready_i is
// high, so items that each give two results are paced by the output port.
module wav_stream_to_pwm_duty_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        at_file_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  pwm_duty_o,
  output logic [15:0] channel_count_o,
  output logic [15:0] sample_bits_o,
  output logic [31:0] rate_hz_o,
  output logic [31:0] payload_bytes_o,
  output logic        last_of_run_o
);
  import wspd_pkg::*;

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhSearch = 3'd1;
  localparam logic [2:0] PhCount  = 3'd2;
  localparam logic [2:0] PhPlay   = 3'd3;
  localparam logic [2:0] PhIdle   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  hpos_q, hpos_d;
  logic [31:0] win_q, win_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] remain_q, remain_d;
  logic [1:0]  fidx_q, fidx_d;
  logic [7:0]  lowb_q, lowb_d;
  logic [7:0]  first_q, first_d;

  result_t     res0, res1;
  logic        push0, push1;

  result_t               queue_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q;
  logic                  accept, pop;

  assign in_ready_o  = (cnt_q <= QueueCntW'(QueueDepth - 2));
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    logic [7:0]  b;
    logic        fend;
    logic [1:0]  bp;
    logic [31:0] rem_new;
    logic [31:0] rem_dec;
    logic        sixteen, stereo, done;
    logic [2:0]  pos, total;
    logic [7:0]  q8, duty;
    logic [8:0]  dsum;

    b    = data_byte_i;
    fend = at_file_end_i;
    bp   = hpos_q[1:0];

    phase_d  = phase_q;
    hpos_d   = hpos_q;
    win_d    = win_q;
    chan_d   = chan_q;
    bits_d   = bits_q;
    rate_d   = rate_q;
    remain_d = remain_q;
    fidx_d   = fidx_q;
    lowb_d   = lowb_q;
    first_d  = first_q;

    res0  = '0;
    res1  = '0;
    res1.event_res   = EvEnd;
    res1.pwm_duty    = CenterDuty;
    res1.last_of_run = 1'b1;
    push0 = 1'b0;
    push1 = 1'b0;

    rem_new = remain_q;
    case (bp)
      2'd0:    rem_new[7:0]   = remain_q[7:0]   | b;
      2'd1:    rem_new[15:8]  = remain_q[15:8]  | b;
      2'd2:    rem_new[23:16] = remain_q[23:16] | b;
      default: rem_new[31:24] = remain_q[31:24] | b;
    endcase
    rem_dec = (remain_q != '0) ? remain_q - 32'd1 : '0;

    sixteen = (bits_q == DepthSixteen);
    stereo  = (chan_q == ChanStereo);
    total   = 3'd1 << ({2'b0, sixteen} + {2'b0, stereo});
    pos     = {1'b0, fidx_q};
    done    = 1'b0;
    q8      = b + {7'd0, b[7] && (lowb_q != '0)};
    duty    = sixteen ? (q8 ^ 8'h80) : b;
    dsum    = {1'b0, first_q} + {1'b0, duty};

    if (kind_i) begin
      phase_d  = PhHeader;
      hpos_d   = '0;
      win_d    = '0;
      chan_d   = '0;
      bits_d   = '0;
      rate_d   = '0;
      remain_d = '0;
      fidx_d   = '0;
      lowb_d   = '0;
      first_d  = '0;
    end else begin
      case (phase_q)
        PhHeader: begin
          win_d = {win_q[23:0], b};
          case (hpos_q)
            6'd22:   chan_d[7:0]   = chan_q[7:0]   | b;
            6'd23:   chan_d[15:8]  = chan_q[15:8]  | b;
            6'd24:   rate_d[7:0]   = rate_q[7:0]   | b;
            6'd25:   rate_d[15:8]  = rate_q[15:8]  | b;
            6'd26:   rate_d[23:16] = rate_q[23:16] | b;
            6'd27:   rate_d[31:24] = rate_q[31:24] | b;
            6'd34:   bits_d[7:0]   = bits_q[7:0]   | b;
            6'd35:   bits_d[15:8]  = bits_q[15:8]  | b;
            default: ;
          endcase
          if ((hpos_q == 6'd3 && win_d != TagRiff) ||
              (hpos_q == 6'd11 && win_d != TagWave) || fend) begin
            res0.event_res   = EvError;
            res0.last_of_run = 1'b1;
            push0            = 1'b1;
            phase_d          = PhIdle;
          end else if (hpos_q >= HeaderLast) begin
            phase_d = PhSearch;
            hpos_d  = '0;
          end else begin
            hpos_d = hpos_q + 6'd1;
          end
        end
        PhSearch: begin
          win_d = {win_q[23:0], b};
          if (fend) begin
            res0.event_res   = EvError;
            res0.last_of_run = 1'b1;
            push0            = 1'b1;
            phase_d          = PhIdle;
          end else if (win_d == TagData) begin
            phase_d  = PhCount;
            hpos_d   = '0;
            remain_d = '0;
          end
        end
        PhCount: begin
          remain_d = rem_new;
          if (bp == 2'd3) begin
            res0.event_res     = EvHeader;
            res0.channel_count = chan_q;
            res0.sample_bits   = bits_q;
            res0.rate_hz       = rate_q;
            res0.payload_bytes = rem_new;
            push0              = 1'b1;
            if (fend || rem_new == '0) begin
              push1   = 1'b1;
              phase_d = PhIdle;
            end else begin
              res0.last_of_run = 1'b1;
              phase_d          = PhPlay;
              fidx_d           = '0;
            end
          end else if (fend) begin
            res0.event_res   = EvError;
            res0.last_of_run = 1'b1;
            push0            = 1'b1;
            phase_d          = PhIdle;
          end else begin
            hpos_d = {4'd0, bp + 2'd1};
          end
        end
        PhPlay: begin
          remain_d = rem_dec;
          if (sixteen && !pos[0]) begin
            lowb_d = b;
            pos    = pos + 3'd1;
          end else if (stereo && (pos + 3'd1 < total)) begin
            first_d = duty;
            pos     = pos + 3'd1;
          end else begin
            res0.event_res = EvSample;
            res0.pwm_duty  = stereo ? dsum[8:1] : duty;
            push0          = 1'b1;
            pos            = '0;
            done           = 1'b1;
          end
          fidx_d = pos[1:0];
          if (fend || (done && rem_dec == '0)) begin
            if (push0) begin
              push1 = 1'b1;
            end else begin
              res0  = res1;
              push0 = 1'b1;
            end
            phase_d = PhIdle;
          end else begin
            res0.last_of_run = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      hpos_q   <= '0;
      win_q    <= '0;
      chan_q   <= '0;
      bits_q   <= '0;
      rate_q   <= '0;
      remain_q <= '0;
      fidx_q   <= '0;
      lowb_q   <= '0;
      first_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      win_q    <= win_d;
      chan_q   <= chan_d;
      bits_q   <= bits_d;
      rate_q   <= rate_d;
      remain_q <= remain_d;
      fidx_q   <= fidx_d;
      lowb_q   <= lowb_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (accept && push1) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + (accept ? QueuePtrW'({1'b0, push0} + {1'b0, push1}) : '0);
      rd_ptr_q <= rd_ptr_q + QueuePtrW'(pop);
      cnt_q    <= cnt_q + (accept ? QueueCntW'({1'b0, push0} + {1'b0, push1}) : '0)
                  - QueueCntW'(pop);
    end
  end

  assign event_res_o     = queue_q[rd_ptr_q].event_res;
  assign pwm_duty_o      = queue_q[rd_ptr_q].pwm_duty;
  assign channel_count_o = queue_q[rd_ptr_q].channel_count;
  assign sample_bits_o   = queue_q[rd_ptr_q].sample_bits;
  assign rate_hz_o       = queue_q[rd_ptr_q].rate_hz;
  assign payload_bytes_o = queue_q[rd_ptr_q].payload_bytes;
  assign last_of_run_o   = queue_q[rd_ptr_q].last_of_run;

endmodule

FILE: sv/wspd_checker.sv
// Port-level checks for the WAV stream to PWM duty core, bound into the core module.
// Depends on wspd_pkg for the event codes and centre duty.
module wspd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  event_res_o,
  input logic [7:0]  pwm_duty_o,
  input logic [15:0] channel_count_o,
  input logic [15:0] sample_bits_o,
  input logic [31:0] rate_hz_o,
  input logic [31:0] payload_bytes_o,
  input logic        last_of_run_o
);
  import wspd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(event_res_o) && $stable(pwm_duty_o)
      && $stable(payload_bytes_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  a_hdr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvHeader |-> channel_count_o == '0
      && sample_bits_o == '0 && rate_hz_o == '0 && payload_bytes_o == '0)
    else $error("header fields set on a non-header result");

  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvEnd |-> pwm_duty_o == CenterDuty && last_of_run_o)
    else $error("end result malformed");

  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvError |-> pwm_duty_o == '0 && last_of_run_o)
    else $error("error result malformed");

endmodule

bind wav_stream_to_pwm_duty_core wspd_checker u_wspd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_res_o     (event_res_o),
  .pwm_duty_o      (pwm_duty_o),
  .channel_count_o (channel_count_o),
  .sample_bits_o   (sample_bits_o),
  .rate_hz_o       (rate_hz_o),
  .payload_bytes_o (payload_bytes_o),
  .last_of_run_o   (last_of_run_o)
);

FILE: sim/tb_top.sv
// Self-checking bench for wav_stream_to_pwm_duty_core: WAV byte items in, duty events out.
// Depends on wspd_pkg and the core; predicts each event in-bench and compares field by field.
`timescale 1ns / 100ps

module tb_top;
  import wspd_pkg::*;

  localparam int CycleLimit = 300000;

  typedef enum logic [2:0] {PhHeader, PhSearch, PhCount, PhPlay, PhIdle} parse_phase_e;

  typedef struct packed {
    logic       drain;
    logic       kind;
    logic [7:0] data;
    logic       fend;
  } wav_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        at_file_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  event_res_o;
  logic [7:0]  pwm_duty_o;
  logic [15:0] channel_count_o;
  logic [15:0] sample_bits_o;
  logic [31:0] rate_hz_o;
  logic [31:0] payload_bytes_o;
  logic        last_of_run_o;

  wav_item_t   wav_bytes_q[$];
  result_t     pwm_events_q[$];
  logic [7:0]  file_bytes[$];
  int          items_accepted = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  logic        steady_run;

  parse_phase_e parse_phase;
  logic [5:0]   hdr_pos;
  logic [31:0]  tag_window;
  logic [15:0]  chan_count_q;
  logic [15:0]  depth_q;
  logic [31:0]  rate_q;
  logic [31:0]  remain_q;
  logic [1:0]   frame_pos;
  logic [7:0]   low_hold;
  logic [7:0]   left_duty;

  wav_stream_to_pwm_duty_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .at_file_end_i   (at_file_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_o     (event_res_o),
    .pwm_duty_o      (pwm_duty_o),
    .channel_count_o (channel_count_o),
    .sample_bits_o   (sample_bits_o),
    .rate_hz_o       (rate_hz_o),
    .payload_bytes_o (payload_bytes_o),
    .last_of_run_o   (last_of_run_o)
  );

  assign steady_run = (items_accepted >= 600) && (items_accepted < 800);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_parser();
    parse_phase  = PhHeader;
    hdr_pos      = '0;
    tag_window   = '0;
    chan_count_q = '0;
    depth_q      = '0;
    rate_q       = '0;
    remain_q     = '0;
    frame_pos    = '0;
    low_hold     = '0;
    left_duty    = '0;
  endtask

  function automatic result_t make_event(input logic [1:0] ev, input logic [7:0] duty,
                                         input logic with_header);
    result_t r;
    r.event_res     = ev;
    r.pwm_duty      = duty;
    r.channel_count = with_header ? chan_count_q : 16'd0;
    r.sample_bits   = with_header ? depth_q : 16'd0;
    r.rate_hz       = with_header ? rate_q : 32'd0;
    r.payload_bytes = with_header ? remain_q : 32'd0;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] sample_to_duty(input logic [7:0] lo, input logic [7:0] hi);
    int s;
    s = $signed({hi, lo});
    return 8'(s / 256 + 128);
  endfunction

  task automatic parse_wav_byte(input logic kind, input logic [7:0] b, input logic fend);
    result_t res[2];
    int      n;
    int      p;
    int      pos;
    int      total;
    int      duty;
    logic    sixteen;
    logic    stereo;
    logic    done;
    n = 0;
    if (kind) begin
      clear_parser();
      return;
    end
    case (parse_phase)
      PhHeader: begin
        p = hdr_pos;
        tag_window = {tag_window[23:0], b};
        if (p >= 22 && p <= 23) chan_count_q = chan_count_q | (16'(b) << ((p - 22) * 8));
        if (p >= 24 && p <= 27) rate_q = rate_q | (32'(b) << ((p - 24) * 8));
        if (p >= 34 && p <= 35) depth_q = depth_q | (16'(b) << ((p - 34) * 8));
        if ((p == 3 && tag_window != TagRiff) || (p == 11 && tag_window != TagWave) ||
            fend) begin
          res[n] = make_event(EvError, 8'd0, 1'b0);
          n++;
          parse_phase = PhIdle;
        end else if (p >= HeaderLast) begin
          parse_phase = PhSearch;
          hdr_pos = '0;
        end else begin
          hdr_pos = 6'(p + 1);
        end
      end
      PhSearch: begin
        tag_window = {tag_window[23:0], b};
        if (fend) begin
          res[n] = make_event(EvError, 8'd0, 1'b0);
          n++;
          parse_phase = PhIdle;
        end else if (tag_window == TagData) begin
          parse_phase = PhCount;
          hdr_pos = '0;
          remain_q = '0;
        end
      end
      PhCount: begin
        p = hdr_pos[1:0];
        remain_q = remain_q | (32'(b) << (p * 8));
        if (p == 3) begin
          res[n] = make_event(EvHeader, 8'd0, 1'b1);
          n++;
          if (fend || remain_q == 0) begin
            res[n] = make_event(EvEnd, CenterDuty, 1'b0);
            n++;
            parse_phase = PhIdle;
          end else begin
            parse_phase = PhPlay;
            frame_pos = '0;
          end
        end else if (fend) begin
          res[n] = make_event(EvError, 8'd0, 1'b0);
          n++;
          parse_phase = PhIdle;
        end else begin
          hdr_pos = 6'(p + 1);
        end
      end
      PhPlay: begin
        sixteen = (depth_q == DepthSixteen);
        stereo  = (chan_count_q == ChanStereo);
        total   = (sixteen ? 2 : 1) * (stereo ? 2 : 1);
        pos     = frame_pos;
        done    = 1'b0;
        if (remain_q != 0) remain_q = remain_q - 1;
        if (sixteen && (pos % 2) == 0) begin
          low_hold = b;
          pos++;
        end else begin
          duty = sixteen ? sample_to_duty(low_hold, b) : b;
          if (stereo && pos + 1 < total) begin
            left_duty = 8'(duty);
            pos++;
          end else begin
            if (stereo) duty = (left_duty + duty) >> 1;
            res[n] = make_event(EvSample, 8'(duty), 1'b0);
            n++;
            pos = 0;
            done = 1'b1;
          end
        end
        frame_pos = 2'(pos);
        if (fend || (done && remain_q == 0)) begin
          res[n] = make_event(EvEnd, CenterDuty, 1'b0);
          n++;
          parse_phase = PhIdle;
        end
      end
      default: begin
      end
    endcase
    if (n > 0) res[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pwm_events_q.push_back(res[i]);
  endtask

  task automatic put_byte(input logic [7:0] v);
    file_bytes.push_back(v);
  endtask

  task automatic put_le(input logic [31:0] v, input int nb);
    for (int i = 0; i < nb; i++) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic put_tag(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic build_header(input logic [15:0] ch, input logic [15:0] bits,
                              input logic [31:0] rate);
    file_bytes.delete();
    put_tag(TagRiff);
    put_le($urandom, 4);
    put_tag(TagWave);
    put_tag(32'h666d_7420);
    put_le(32'd16, 4);
    put_le($urandom, 2);
    put_le(ch, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(bits, 2);
  endtask

  task automatic add_data_chunk(input int junk, input logic [31:0] count, input int nbytes);
    for (int i = 0; i < junk; i++) put_byte(8'($urandom));
    if (junk >= 3 && $urandom_range(2) == 0) put_le(32'h0074_6164, 3);
    put_tag(TagData);
    put_le(count, 4);
    for (int i = 0; i < nbytes; i++) put_byte(8'($urandom));
  endtask

  task automatic push_file(input int cut, input logic fend_last);
    wav_item_t it;
    for (int i = 0; i < cut; i++) begin
      it.drain = 1'b0;
      it.kind  = 1'b0;
      it.data  = file_bytes[i];
      it.fend  = fend_last && (i == cut - 1);
      wav_bytes_q.push_back(it);
    end
  endtask

  task automatic push_start(input logic drain);
    wav_item_t it;
    it.drain = drain;
    it.kind  = 1'b1;
    it.data  = 8'($urandom);
    it.fend  = 1'($urandom_range(1));
    wav_bytes_q.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin : stim_gen
    int          pick;
    int          variant;
    int          nb;
    int          junk;
    int          hdr_len;
    int          target;
    int          file_idx;
    int          idx;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] count;

    clear_parser();

    // mono 16-bit, extremes of the sample range, count runs out
    build_header(16'd1, 16'd16, 32'd8000);
    add_data_chunk(0, 32'd8, 0);
    put_le(32'h7FFF_8000, 4);
    put_le(32'h0100_FF80, 4);
    put_le(32'h0000_A55A, 2);
    push_file(file_bytes.size(), 1'b0);

    push_start(1'b0);
    build_header(16'd1, 16'd16, 32'd8000);
    add_data_chunk(0, 32'd4, 4);
    file_bytes[0] = 8'h58;
    push_file(file_bytes.size(), 1'b0);

    push_start(1'b0);
    build_header(16'd1, 16'd16, 32'd8000);
    add_data_chunk(0, 32'd4, 4);
    file_bytes[9] = file_bytes[9] ^ 8'h20;
    push_file(file_bytes.size(), 1'b1);

    push_start(1'b1);
    build_header(16'd2, 16'd16, 32'd0);
    add_data_chunk(0, 32'd8, 0);
    put_le(32'h7FFF_7FFF, 4);
    put_le(32'h7FFF_8000, 4);
    push_file(file_bytes.size(), 1'b1);

    push_start(1'b0);
    build_header(16'd2, 16'd8, 32'd11025);
    add_data_chunk(0, 32'd3, 0);
    put_le(32'hFE01_FF00, 4);
    push_file(file_bytes.size(), 1'b0);

    push_start(1'b0);
    build_header(16'hFFFF, 16'd24, 32'hFFFF_FFFF);
    add_data_chunk(0, 32'hFFFF_FFFF, 0);
    put_le(32'h0080_FF00, 3);
    push_file(file_bytes.size(), 1'b1);

    push_start(1'b0);
    build_header(16'd1, 16'd8, 32'd44100);
    add_data_chunk(0, 32'd0, 0);
    push_file(file_bytes.size(), 1'b0);

    push_start(1'b0);
    build_header(16'd1, 16'd8, 32'd44100);
    add_data_chunk(0, 32'd5, 0);
    push_file(file_bytes.size(), 1'b1);

    push_start(1'b0);
    build_header(16'd1, 16'd16, 32'd48000);
    put_le($urandom, 4);
    put_le($urandom, 2);
    push_file(file_bytes.size(), 1'b1);

    push_start(1'b0);
    build_header(16'd1, 16'd16, 32'd48000);
    add_data_chunk(0, 32'd8, 0);
    push_file(42, 1'b1);

    push_start(1'b0);
    build_header(16'd1, 16'd16, 32'd48000);
    push_file(20, 1'b1);

    push_start(1'b0);
    build_header(16'd1, 16'd8, 32'd22050);
    file_bytes[33] = 8'h64;
    file_bytes[34] = 8'h61;
    file_bytes[35] = 8'h74;
    put_byte(8'h61);
    put_le(32'd2, 4);
    put_le(32'h0000_807F, 2);
    push_file(file_bytes.size(), 1'b0);

    push_start(1'b0);
    build_header(16'd2, 16'd16, 32'd96000);
    add_data_chunk(0, 32'd100, 3);
    push_file(file_bytes.size(), 1'b1);

    push_start(1'b0);
    build_header(16'd1, 16'd8, 32'd8000);
    add_data_chunk(0, 32'd10, 3);
    push_file(file_bytes.size(), 1'b0);

    target = 1200;
    file_idx = 0;
    while (wav_bytes_q.size() < target) begin
      push_start(file_idx % 6 == 0);
      file_idx++;
      pick = $urandom_range(99);
      idx = $urandom_range(9);
      ch = (idx < 4) ? 16'd1 : (idx < 8) ? 16'd2 : 16'($urandom);
      idx = $urandom_range(9);
      bits = (idx < 4) ? 16'd16 : (idx < 8) ? 16'd8 : 16'($urandom);
      count = ($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(48));
      nb = (count > 48) ? $urandom_range(1, 40) : int'(count);
      junk = $urandom_range(5);
      build_header(ch, bits, 32'($urandom));
      if (pick < 75) begin
        variant = (count > 48) ? 4 : $urandom_range(3);
        if (variant == 1) nb = nb + $urandom_range(1, 4);
        add_data_chunk(junk, count, nb);
        hdr_len = file_bytes.size() - nb;
        case (variant)
          0, 1: push_file(file_bytes.size(), 1'($urandom_range(1)));
          2: push_file($urandom_range(hdr_len, file_bytes.size()), 1'b1);
          3: push_file($urandom_range(1, file_bytes.size()), 1'b0);
          default: push_file(file_bytes.size(), 1'b1);
        endcase
      end else if (pick < 85) begin
        add_data_chunk(junk, count, nb);
        idx = $urandom_range(1) ? $urandom_range(3) : $urandom_range(8, 11);
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
        push_file(file_bytes.size(), 1'($urandom_range(1)));
      end else if (pick < 95) begin
        add_data_chunk(junk, count, nb);
        push_file($urandom_range(1, file_bytes.size() - nb), 1'b1);
      end else begin
        file_bytes.delete();
        for (int i = $urandom_range(1, 20); i > 0; i--) put_byte(8'($urandom));
        push_file(file_bytes.size(), 1'($urandom_range(1)));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (wav_bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pwm_events_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pwm_events_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    wav_item_t nxt;
    logic      offer;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      kind_i        <= 1'b0;
      data_byte_i   <= 8'd0;
      at_file_end_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        parse_wav_byte(kind_i, data_byte_i, at_file_end_i);
        items_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (wav_bytes_q.size() != 0 &&
            !(wav_bytes_q[0].drain && pwm_events_q.size() != 0) &&
            (steady_run || $urandom_range(99) >= 18)) begin
          nxt = wav_bytes_q.pop_front();
          kind_i        <= nxt.kind;
          data_byte_i   <= nxt.data;
          at_file_end_i <= nxt.fend;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : ready_gen
    int   hold_left;
    logic hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && items_accepted > 300 && pwm_events_q.size() != 0) begin
      // hold off long enough for the result queue to fill and stall the input
      hold_done = 1'b1;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady_run || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin : event_monitor
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pwm_events_q.size() == 0) begin
        $display("%0t: event %0d duty %0h arrived with none expected",
                 $time, event_res_o, pwm_duty_o);
        mismatches++;
      end else begin
        want = pwm_events_q.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(event_res_o));
        check_field("pwm_duty", 32'(want.pwm_duty), 32'(pwm_duty_o));
        check_field("channel_count", 32'(want.channel_count), 32'(channel_count_o));
        check_field("sample_bits", 32'(want.sample_bits), 32'(sample_bits_o));
        check_field("rate_hz", want.rate_hz, rate_hz_o);
        check_field("payload_bytes", want.payload_bytes, payload_bytes_o);
        check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
